@@ src/ipwd_pkg.sv @@
package ipwd_pkg;

  // Fixed field and register widths
  localparam int REG_BITS       = 24;
  localparam int CODE_BITS      = 8;
  localparam int TALLY_BITS     = 5;
  localparam int EDGE_TIME_BITS = 32;
  localparam int CFG_IDX_BITS   = 3;

  // Defaults for the top-level parameters
  localparam int FRAME_BITS_DEF = 24;
  localparam int STAMP_BITS_DEF = 32;

  // Register reset values
  localparam logic [REG_BITS-1:0] START_MIN_RST = REG_BITS'(50000);
  localparam logic [REG_BITS-1:0] WIN_A_RST     = REG_BITS'(400);
  localparam logic [REG_BITS-1:0] WIN_B_RST     = REG_BITS'(450);
  localparam logic [REG_BITS-1:0] WIN_C_RST     = REG_BITS'(480);
  localparam logic [REG_BITS-1:0] WIN_D_RST     = REG_BITS'(1000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_MIN = 3'd0,
    REG_WIN_A     = 3'd1,
    REG_WIN_B     = 3'd2,
    REG_WIN_C     = 3'd3,
    REG_WIN_D     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_BITS-1:0] start_min;
    logic [REG_BITS-1:0] win_a;
    logic [REG_BITS-1:0] win_b;
    logic [REG_BITS-1:0] win_c;
    logic [REG_BITS-1:0] win_d;
  } cfg_regs_t;

  // Bit pairs shifted into the code for each duration window
  typedef enum logic [1:0] {
    PAIR_SHORT_HIGH = 2'b00,
    PAIR_LONG_HIGH  = 2'b01,
    PAIR_MID_LOW    = 2'b10,
    PAIR_LONG_LOW   = 2'b11
  } pair_t;

  typedef struct packed {
    logic  hit;
    pair_t pair;
  } win_hit_t;

  // Fixed list of accepted codes
  function automatic logic code_accepted(input logic [CODE_BITS-1:0] code);
    logic ok;
    case (code) inside
      8'd0, 8'd2, 8'd8, 8'd11, 8'd32, 8'd34,
      8'd35, 8'd38, 8'd44, 8'd130, 8'd134, 8'd138: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ src/ipwd_ifs.sv @@
// Edge request channel
interface ipwd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                edge_level;
  logic [ipwd_pkg::EDGE_TIME_BITS-1:0] edge_time;

  modport source (output valid, output edge_level, output edge_time, input ready);
  modport sink (input valid, input edge_level, input edge_time, output ready);
endinterface

// Frame result channel
interface ipwd_out_if;
  logic                           valid;
  logic                           ready;
  logic [ipwd_pkg::CODE_BITS-1:0] frame_code;
  logic                           frame_status;

  modport source (output valid, output frame_code, output frame_status, input ready);
  modport sink (input valid, input frame_code, input frame_status, output ready);
endinterface

@@ src/ir_pulse_width_decoder_core.sv @@
// IR pulse-width decoder: one edge request per cycle, results on a valid/ready channel.
// Path: the closing edge is held in the input register, then decoded into the result register;
// it waits in the input register while an unread result holds the result register.
// Throughput: one edge per cycle; the input stalls only while a result waits unread.
// Reset (rst_n low, synchronous): registers to defaults, timing state cleared, decoder idle.
module ir_pulse_width_decoder_core #(
  parameter int FRAME_BITS = ipwd_pkg::FRAME_BITS_DEF,
  parameter int STAMP_BITS = ipwd_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ipwd_in_if.sink                           in_ch,
  ipwd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ipwd_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [ipwd_pkg::REG_BITS-1:0]     cfg_data
);
  import ipwd_pkg::*;

  localparam int CMP_W = (STAMP_BITS > REG_BITS) ? STAMP_BITS : REG_BITS;
  localparam logic [TALLY_BITS-1:0] TALLY_LIMIT = TALLY_BITS'(FRAME_BITS - 1);

  // Configuration registers
  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min <= START_MIN_RST;
      cfg_r.win_a     <= WIN_A_RST;
      cfg_r.win_b     <= WIN_B_RST;
      cfg_r.win_c     <= WIN_C_RST;
      cfg_r.win_d     <= WIN_D_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_START_MIN: cfg_r.start_min <= cfg_data;
        REG_WIN_A:     cfg_r.win_a     <= cfg_data;
        REG_WIN_B:     cfg_r.win_b     <= cfg_data;
        REG_WIN_C:     cfg_r.win_c     <= cfg_data;
        REG_WIN_D:     cfg_r.win_d     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  logic                  s1_vld_r;
  logic                  s1_level_r;
  logic [STAMP_BITS-1:0] s1_time_r;
  logic                  out_vld_r;
  logic                  adv;
  logic                  s1_fire;

  assign adv          = !out_vld_r || out_ch.ready;
  assign s1_fire      = s1_vld_r && adv;
  assign in_ch.ready  = !s1_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_level_r <= in_ch.edge_level;
      s1_time_r  <= in_ch.edge_time[STAMP_BITS-1:0];
    end
  end

  // Decoder state
  logic [STAMP_BITS-1:0] last_r, last_nxt;
  logic [STAMP_BITS-1:0] low_r, low_nxt;
  logic [STAMP_BITS-1:0] high_r, high_nxt;
  logic                  in_frame_r, in_frame_nxt;
  logic [TALLY_BITS-1:0] tally_r, tally_nxt;
  logic [CODE_BITS-1:0]  code_r, code_nxt;

  logic [STAMP_BITS-1:0] span;
  logic [TALLY_BITS-1:0] tally_v;
  logic [CODE_BITS-1:0]  code_v;
  logic                  res_fire;
  logic [CODE_BITS-1:0]  res_code;
  win_hit_t              hit;

  assign span = s1_time_r - last_r;

  ipwd_window_cls #(
    .STAMP_BITS(STAMP_BITS)
  ) u_cls (
    .high_span(span),
    .low_span (low_r),
    .cfg      (cfg_r),
    .hit      (hit)
  );

  // Per-edge decode
  always_comb begin
    last_nxt     = last_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    in_frame_nxt = in_frame_r;
    tally_nxt    = tally_r;
    code_nxt     = code_r;
    tally_v      = tally_r;
    code_v       = code_r;
    res_fire     = 1'b0;
    res_code     = code_r;
    if (s1_fire) begin
      last_nxt = s1_time_r;
      if (s1_level_r) begin
        low_nxt = span;
      end else begin
        high_nxt = span;
        if (!in_frame_r) begin
          // idle: a long high opens a frame
          if (CMP_W'(span) > CMP_W'(cfg_r.start_min)) begin
            in_frame_nxt = 1'b1;
            tally_nxt    = '0;
            code_nxt     = '0;
          end
        end else begin
          if ((tally_r < TALLY_LIMIT) && hit.hit) begin
            code_v  = {code_r[CODE_BITS-3:0], hit.pair};
            tally_v = tally_r + TALLY_BITS'(2);
          end
          if (tally_v >= TALLY_LIMIT) begin
            // frame complete: emit and clear
            res_fire     = 1'b1;
            res_code     = code_v;
            in_frame_nxt = 1'b0;
            tally_nxt    = '0;
            code_nxt     = '0;
            low_nxt      = '0;
            high_nxt     = '0;
          end else begin
            tally_nxt = tally_v;
            code_nxt  = code_v;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r     <= '0;
      low_r      <= '0;
      high_r     <= '0;
      in_frame_r <= 1'b0;
      tally_r    <= '0;
      code_r     <= '0;
    end else begin
      last_r     <= last_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      in_frame_r <= in_frame_nxt;
      tally_r    <= tally_nxt;
      code_r     <= code_nxt;
    end
  end

  // Result register
  logic [CODE_BITS-1:0] out_code_r;
  logic                 out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_code_r   <= res_code;
      out_status_r <= !code_accepted(res_code);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.frame_code   = out_code_r;
  assign out_ch.frame_status = out_status_r;

`ifndef SYNTHESIS
  // an idle decoder holds no partial code
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (tally_r == '0) && (code_r == '0))
    else $error("idle decoder holds partial frame state");

  // the bit count never runs past the frame length
  a_tally_max: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= TALLY_BITS'(FRAME_BITS))
    else $error("bit tally beyond frame length");

  // a closing edge leaves the decoder idle with cleared spans
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> !in_frame_r && (low_r == '0) && (high_r == '0) && out_vld_r)
    else $error("frame close did not reset decoder");

  // a new result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !out_vld_r || out_ch.ready)
    else $error("result register overrun");
`endif

endmodule

@@ src/ipwd_window_cls.sv @@
// Tries the four duration windows in priority order and picks the bit pair.
module ipwd_window_cls #(
  parameter int STAMP_BITS = ipwd_pkg::STAMP_BITS_DEF
) (
  input  logic [STAMP_BITS-1:0] high_span,
  input  logic [STAMP_BITS-1:0] low_span,
  input  ipwd_pkg::cfg_regs_t   cfg,
  output ipwd_pkg::win_hit_t    hit
);
  import ipwd_pkg::*;

  localparam int CMP_W = (STAMP_BITS > REG_BITS) ? STAMP_BITS : REG_BITS;

  logic [CMP_W-1:0] hi_x, lo_x, a_x, b_x, c_x, d_x;
  logic short_high, mid_low, long_high, long_low;

  assign hi_x = CMP_W'(high_span);
  assign lo_x = CMP_W'(low_span);
  assign a_x  = CMP_W'(cfg.win_a);
  assign b_x  = CMP_W'(cfg.win_b);
  assign c_x  = CMP_W'(cfg.win_c);
  assign d_x  = CMP_W'(cfg.win_d);

  // strict bounds on both sides
  assign short_high = (hi_x > a_x) && (hi_x < b_x);
  assign mid_low    = (lo_x > b_x) && (lo_x < c_x);
  assign long_high  = (hi_x > c_x) && (hi_x < d_x);
  assign long_low   = (lo_x > c_x) && (lo_x < d_x);

  always_comb begin
    hit.hit  = 1'b1;
    hit.pair = PAIR_SHORT_HIGH;
    if (short_high) begin
      hit.pair = PAIR_SHORT_HIGH;
    end else if (mid_low) begin
      hit.pair = PAIR_MID_LOW;
    end else if (long_high) begin
      hit.pair = PAIR_LONG_HIGH;
    end else if (long_low) begin
      hit.pair = PAIR_LONG_LOW;
    end else begin
      hit.hit = 1'b0;
    end
  end

endmodule

@@ dv/ipwd_frame_checker.sv @@
`timescale 1ns / 100ps

// Watches the edge and frame channels, predicts decoded frames and compares them
module ipwd_frame_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  ipwd_in_if                                in_mon,
  ipwd_out_if                               out_mon,
  input  logic                              cfg_we,
  input  logic [ipwd_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [ipwd_pkg::REG_BITS-1:0]     cfg_data,
  output int                                mismatch_count,
  output int                                frames_pending
);
  import ipwd_pkg::*;

  localparam int FRAME_BITS = FRAME_BITS_DEF;
  localparam int STAMP_BITS = STAMP_BITS_DEF;
  localparam logic STATUS_ACCEPTED = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;
  localparam logic [CODE_BITS-1:0] ACCEPTED_LIST [12] = '{
    8'd0, 8'd2, 8'd8, 8'd11, 8'd32, 8'd34, 8'd35, 8'd38, 8'd44, 8'd130, 8'd134, 8'd138
  };

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 status;
  } frame_t;

  frame_t expected_frames[$];
  frame_t oldest;

  // Register copy
  logic [REG_BITS-1:0] start_min, win_a, win_b, win_c, win_d;

  // Timing and decode state
  logic [STAMP_BITS-1:0] prev_stamp, low_width, high_width;
  logic                  framing;
  logic [TALLY_BITS-1:0] bits_taken;
  logic [CODE_BITS-1:0]  code_acc;

  function automatic logic on_accept_list(input logic [CODE_BITS-1:0] code);
    logic hit;
    hit = 1'b0;
    foreach (ACCEPTED_LIST[i]) begin
      if (ACCEPTED_LIST[i] == code) hit = 1'b1;
    end
    return hit;
  endfunction

  // Strict window test, bounds zero-extended to the stamp width
  function automatic logic in_window(input logic [STAMP_BITS-1:0] v,
                                     input logic [REG_BITS-1:0] lo,
                                     input logic [REG_BITS-1:0] hi);
    return (v > STAMP_BITS'(lo)) && (v < STAMP_BITS'(hi));
  endfunction

  function void shift_in(input pair_t p);
    code_acc   = {code_acc[CODE_BITS-3:0], p};
    bits_taken = bits_taken + TALLY_BITS'(2);
  endfunction

  function void clear_decode();
    framing    = 1'b0;
    bits_taken = '0;
    code_acc   = '0;
    low_width  = '0;
    high_width = '0;
  endfunction

  // Apply one edge request to the decode state, queue a frame if one closes
  function void decode_edge(input logic lvl, input logic [EDGE_TIME_BITS-1:0] t);
    logic [STAMP_BITS-1:0] now, width;
    now        = t[STAMP_BITS-1:0];
    width      = now - prev_stamp;
    prev_stamp = now;
    if (lvl) begin
      low_width = width;
      return;
    end
    high_width = width;

    // idle: only a long high opens a frame
    if (!framing) begin
      if (high_width > STAMP_BITS'(start_min)) begin
        framing    = 1'b1;
        bits_taken = '0;
        code_acc   = '0;
      end
      return;
    end

    // windows in fixed priority order
    if (bits_taken < FRAME_BITS - 1) begin
      if (in_window(high_width, win_a, win_b))      shift_in(PAIR_SHORT_HIGH);
      else if (in_window(low_width, win_b, win_c))  shift_in(PAIR_MID_LOW);
      else if (in_window(high_width, win_c, win_d)) shift_in(PAIR_LONG_HIGH);
      else if (in_window(low_width, win_c, win_d))  shift_in(PAIR_LONG_LOW);
    end

    if (bits_taken >= FRAME_BITS - 1) begin
      expected_frames.push_back('{code: code_acc,
          status: on_accept_list(code_acc) ? STATUS_ACCEPTED : STATUS_REJECTED});
      clear_decode();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start_min      = START_MIN_RST;
      win_a          = WIN_A_RST;
      win_b          = WIN_B_RST;
      win_c          = WIN_C_RST;
      win_d          = WIN_D_RST;
      prev_stamp     = '0;
      clear_decode();
      expected_frames.delete();
      mismatch_count = 0;
    end else begin
      // register writes, unknown indexes dropped
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_START_MIN: start_min = cfg_data;
          REG_WIN_A:     win_a = cfg_data;
          REG_WIN_B:     win_b = cfg_data;
          REG_WIN_C:     win_c = cfg_data;
          REG_WIN_D:     win_d = cfg_data;
          default: ;
        endcase
      end

      // compare a delivered frame with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected frame: frame_code %0d frame_status %0d",
                 out_mon.frame_code, out_mon.frame_status);
          mismatch_count++;
        end else begin
          oldest = expected_frames.pop_front();
          if (out_mon.frame_code !== oldest.code) begin
            $error("frame_code: expected %0d, actual %0d", oldest.code, out_mon.frame_code);
            mismatch_count++;
          end
          if (out_mon.frame_status !== oldest.status) begin
            $error("frame_status: expected %0d, actual %0d",
                   oldest.status, out_mon.frame_status);
            mismatch_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) decode_edge(in_mon.edge_level, in_mon.edge_time);
    end
    frames_pending = expected_frames.size();
  end

endmodule

@@ dv/ir_pulse_width_decoder_core_test.sv @@
`timescale 1ns / 100ps

module ir_pulse_width_decoder_core_test;
  import ipwd_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 12;
  localparam int SETTLE_CYCLES    = 6;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RUN_LIMIT_CYCLES = 300000;
  localparam int PHASE_EDGES      = 245;
  localparam int EXTREME_EDGES    = 40;
  localparam int MODE_STEP        = 470;
  localparam int PAIRS_PER_FRAME  = 12;
  localparam int SPAN_SLACK       = 300;
  localparam logic [REG_BITS-1:0] REG_MAX = '1;
  localparam logic [CFG_IDX_BITS-1:0] FIRST_UNUSED_REG = CFG_IDX_BITS'(REG_WIN_D) + 1'b1;
  localparam logic [CODE_BITS-1:0] LISTED_CODES [12] = '{
    8'd0, 8'd2, 8'd8, 8'd11, 8'd32, 8'd34, 8'd35, 8'd38, 8'd44, 8'd130, 8'd134, 8'd138
  };

  typedef enum {SET_RANDOM, SET_TIGHT, SET_ZERO, SET_ONES, SET_NEAR_MAX} reg_set_t;
  typedef enum {MODE_SLOW_SINK, MODE_SLOW_SOURCE, MODE_NO_IDLE} idle_mode_t;

  localparam reg_set_t SET_ORDER [6] = '{
    SET_RANDOM, SET_ZERO, SET_TIGHT, SET_ONES, SET_NEAR_MAX, SET_RANDOM
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [REG_BITS-1:0] cfg_data;
  int mismatch_count, frames_pending;

  ipwd_in_if  edges();
  ipwd_out_if frames();

  ir_pulse_width_decoder_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (edges),
    .out_ch   (frames),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  ipwd_frame_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (edges),
    .out_mon        (frames),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .frames_pending (frames_pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stimulus-side view of the registers and line time
  logic [REG_BITS-1:0] start_ticks, bound_a, bound_b, bound_c, bound_d;
  logic [EDGE_TIME_BITS-1:0] stamp;
  idle_mode_t idle_mode;
  int edges_sent;
  bit hold_req;

  function automatic bit sender_pause();
    return (idle_mode == MODE_SLOW_SINK && $urandom_range(99) < 19) ||
           (idle_mode == MODE_SLOW_SOURCE && $urandom_range(99) < 65);
  endfunction

  function automatic bit receiver_pause();
    return (idle_mode == MODE_SLOW_SINK && $urandom_range(99) < 65) ||
           (idle_mode == MODE_SLOW_SOURCE && $urandom_range(99) < 19);
  endfunction

  function automatic logic [31:0] span_inside(input logic [REG_BITS-1:0] lo,
                                              input logic [REG_BITS-1:0] hi);
    return $urandom_range(32'(lo) + 1, 32'(hi) - 1);
  endfunction

  // Any span outside the open window (lo, hi), bounds included
  function automatic logic [31:0] span_outside(input logic [REG_BITS-1:0] lo,
                                               input logic [REG_BITS-1:0] hi);
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = 32'(lo);
      1: v = 32'(hi);
      2: v = $urandom_range(32'(lo));
      default: v = $urandom_range(32'(hi) + SPAN_SLACK, 32'(hi));
    endcase
    return v;
  endfunction

  // One edge request, with optional gap cycles in front
  task automatic send_edge(input logic lvl, input logic [EDGE_TIME_BITS-1:0] t);
    while (sender_pause()) begin
      edges.valid <= 1'b0;
      @(posedge clk);
    end
    edges.valid      <= 1'b1;
    edges.edge_level <= lvl;
    edges.edge_time  <= t;
    do @(posedge clk); while (!edges.ready);
    edges_sent++;
    idle_mode = (edges_sent < MODE_STEP) ? MODE_SLOW_SINK :
                (edges_sent < 2 * MODE_STEP) ? MODE_SLOW_SOURCE : MODE_NO_IDLE;
  endtask

  // Low for low_t ticks, then high for high_t ticks
  task automatic send_spans(input logic [31:0] low_t, input logic [31:0] high_t);
    stamp += low_t;
    send_edge(1'b1, stamp);
    stamp += high_t;
    send_edge(1'b0, stamp);
  endtask

  // Durations chosen so the first matching window is the one for p
  task automatic send_pair(input pair_t p);
    logic [31:0] low_t, high_t;
    case (p)
      PAIR_SHORT_HIGH: begin
        high_t = span_inside(bound_a, bound_b);
        low_t  = $urandom_range(32'(bound_d) + SPAN_SLACK);
      end
      PAIR_MID_LOW: begin
        low_t  = span_inside(bound_b, bound_c);
        high_t = span_outside(bound_a, bound_b);
      end
      PAIR_LONG_HIGH: begin
        high_t = span_inside(bound_c, bound_d);
        low_t  = span_outside(bound_b, bound_c);
      end
      default: begin
        low_t = span_inside(bound_c, bound_d);
        case ($urandom_range(2))
          0: high_t = $urandom_range(32'(bound_a));
          1: high_t = $urandom_range(32'(bound_c), 32'(bound_b));
          default: high_t = $urandom_range(32'(bound_d) + SPAN_SLACK, 32'(bound_d));
        endcase
      end
    endcase
    send_spans(low_t, high_t);
  endtask

  task automatic send_start_pulse();
    send_spans($urandom_range(2000), 32'(start_ticks) + 1 + $urandom_range(5000));
  endtask

  // Well-formed pairs: close any open frame, leave the decoder idle
  task automatic resync();
    repeat (PAIRS_PER_FRAME) send_pair(pair_t'($urandom_range(3)));
  endtask

  task automatic send_frame(input logic [CODE_BITS-1:0] tail);
    send_start_pulse();
    repeat (PAIRS_PER_FRAME - 4) send_pair(pair_t'($urandom_range(3)));
    for (int k = 0; k < 4; k++) send_pair(pair_t'(tail[CODE_BITS-1-2*k -: 2]));
  endtask

  // Random edge: short or huge steps, jumps back, spans near the start threshold
  task automatic noise_edge();
    case ($urandom_range(3))
      0: stamp += $urandom_range(2000);
      1: stamp += $urandom;
      2: stamp = $urandom;
      default: stamp += 32'(start_ticks) + $urandom_range(10);
    endcase
    send_edge(1'($urandom_range(1)), stamp);
  endtask

  task automatic run_unit();
    int roll;
    logic [CODE_BITS-1:0] tail;
    roll = $urandom_range(99);
    if (roll < 75) begin
      tail = $urandom_range(1) ? LISTED_CODES[$urandom_range(11)] : 8'($urandom_range(255));
      send_frame(tail);
    end else if (roll < 90) begin
      // frame cut short
      send_start_pulse();
      repeat ($urandom_range(11, 1)) send_pair(pair_t'($urandom_range(3)));
      resync();
    end else begin
      repeat ($urandom_range(6, 1)) noise_edge();
      resync();
    end
  endtask

  task automatic run_phase(input int n);
    int target;
    target = edges_sent + n;
    resync();
    while (edges_sent < target) run_unit();
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Registers change only once the decoder has drained
  task automatic program_regs(input logic [REG_BITS-1:0] s, input logic [REG_BITS-1:0] a,
                              input logic [REG_BITS-1:0] b, input logic [REG_BITS-1:0] c,
                              input logic [REG_BITS-1:0] d);
    edges.valid <= 1'b0;
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_START_MIN, s);
    write_reg(REG_WIN_A, a);
    write_reg(REG_WIN_B, b);
    write_reg(REG_WIN_C, c);
    write_reg(REG_WIN_D, d);
    // indexes past the register list must be ignored
    for (int k = FIRST_UNUSED_REG; k < 2 ** CFG_IDX_BITS; k++)
      write_reg(CFG_IDX_BITS'(k), REG_BITS'($urandom));
    cfg_we <= 1'b0;
    start_ticks = s;
    bound_a     = a;
    bound_b     = b;
    bound_c     = c;
    bound_d     = d;
  endtask

  // Other than zero/ones: windows two or more ticks apart, start above any pair span
  task automatic apply_set(input reg_set_t kind);
    logic [REG_BITS-1:0] a, b, c, d;
    case (kind)
      SET_ZERO: program_regs('0, '0, '0, '0, '0);
      SET_ONES: program_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
      SET_TIGHT: begin
        a = REG_BITS'($urandom_range(100));
        program_regs(a + REG_BITS'(6 + SPAN_SLACK + 1), a, a + REG_BITS'(2),
                     a + REG_BITS'(4), a + REG_BITS'(6));
      end
      SET_NEAR_MAX: begin
        d = REG_MAX - REG_BITS'(400);
        c = d - REG_BITS'($urandom_range(60, 2));
        b = c - REG_BITS'($urandom_range(60, 2));
        a = b - REG_BITS'($urandom_range(60, 2));
        program_regs(REG_MAX, a, b, c, d);
      end
      default: begin
        a = REG_BITS'($urandom_range(4000));
        b = a + REG_BITS'($urandom_range(300, 2));
        c = b + REG_BITS'($urandom_range(300, 2));
        d = c + REG_BITS'($urandom_range(3000, 2));
        program_regs(d + REG_BITS'(SPAN_SLACK + 1 + $urandom_range(100000)), a, b, c, d);
      end
    endcase
  endtask

  // Result side: random stalls, plus one long hold-off while requests keep coming
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    frames.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        frames.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      frames.ready <= !receiver_pause();
    end
  end

  initial begin
    #(2 * HALF_PERIOD * RUN_LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    edges.valid      <= 1'b0;
    edges.edge_level <= 1'b0;
    edges.edge_time  <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_START_MIN;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    stamp       = '0;
    edges_sent  = 0;
    idle_mode   = MODE_SLOW_SINK;
    hold_req    = 1'b0;
    start_ticks = START_MIN_RST;
    bound_a     = WIN_A_RST;
    bound_b     = WIN_B_RST;
    bound_c     = WIN_C_RST;
    bound_d     = WIN_D_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset thresholds: start at and just past threshold
    send_spans(0, 50000);
    send_spans(10, 50001);
    // window bounds and priority
    send_spans(100, 401);     // short high
    send_spans(451, 449);     // short high wins over mid low
    send_spans(451, 450);     // mid low
    send_spans(479, 999);     // mid low wins over long high
    send_spans(480, 481);     // long high
    send_spans(481, 1000);    // long low
    send_spans(999, 60000);   // long high inside a frame: no restart, long low
    send_spans(1000, 400);    // all bounds exact: nothing shifted
    // stamp at all ones, next stamp wraps past zero
    stamp = '1;
    send_edge(1'b1, stamp);
    stamp += 410;
    send_edge(1'b0, stamp);
    // last four pairs give an accepted code
    send_spans(0, 420);
    send_spans(465, 0);
    send_spans(0, 449);
    send_spans(700, 2000);

    // Random part, reset thresholds first
    run_phase(PHASE_EDGES);
    foreach (SET_ORDER[i]) begin
      apply_set(SET_ORDER[i]);
      if (i == 2) hold_req = 1'b1;
      if (SET_ORDER[i] == SET_ZERO || SET_ORDER[i] == SET_ONES)
        repeat (EXTREME_EDGES) noise_edge();
      else
        run_phase(PHASE_EDGES);
    end

    edges.valid <= 1'b0;
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
